FILE: hw/rtl/drbp_pkg.sv
// ----------------------------------------------------------------------------
// drbp_pkg
// Shared types and constants for the depth rectangle back-projection block.
// ----------------------------------------------------------------------------
package drbp_pkg;

    localparam int unsigned COORD_W    = 12;
    localparam int unsigned BOUND_W    = 13;
    localparam int unsigned DEPTH_W    = 16;
    localparam int unsigned CENTER_W   = 16;
    localparam int unsigned INV_W      = 24;
    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned POINT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // fixed point: 1/f carries 24 fraction bits
    localparam int unsigned FRAC_SHIFT = 24;
    // reciprocal shift for the stride remainder; exact for 12-bit offsets
    // at strides up to 16
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = 25;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT       = 3'd0,
        CFG_RECT_TOP        = 3'd1,
        CFG_RECT_RIGHT      = 3'd2,
        CFG_RECT_BOTTOM     = 3'd3,
        CFG_PRINCIPAL_POINT = 3'd4,
        CFG_INV_FOCAL_X     = 3'd5,
        CFG_INV_FOCAL_Y     = 3'd6,
        CFG_MAX_DEPTH_RAW   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0]  rect_left;
        logic [COORD_W-1:0]  rect_top;
        logic [BOUND_W-1:0]  rect_right;
        logic [BOUND_W-1:0]  rect_bottom;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [DEPTH_W-1:0]  max_depth_raw;
    } t_cfg;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // fields that ride along the pipeline unchanged
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pass;

endpackage

FILE: hw/rtl/drbp_pixel_if.sv
// ----------------------------------------------------------------------------
// drbp_pixel_if
// Input channel: one depth pixel word with position and color.
// ----------------------------------------------------------------------------
interface drbp_pixel_if;
    import drbp_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [DEPTH_W-1:0] depth_raw;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;

    modport source (
        output valid, pixel_col, pixel_row, depth_raw, red_in, green_in, blue_in,
        input  ready
    );

    modport sink (
        input  valid, pixel_col, pixel_row, depth_raw, red_in, green_in, blue_in,
        output ready
    );

endinterface

FILE: hw/rtl/drbp_point_if.sv
// ----------------------------------------------------------------------------
// drbp_point_if
// Output channel: one back-projected point word with color.
// ----------------------------------------------------------------------------
interface drbp_point_if;
    import drbp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic [COLOR_W-1:0]        red_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        blue_out;

    modport source (
        output valid, point_x, point_y, point_z, red_out, green_out, blue_out,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, red_out, green_out, blue_out,
        output ready
    );

endinterface

FILE: hw/rtl/depth_rect_backprojection_top.sv
// ----------------------------------------------------------------------------
// depth_rect_backprojection_top
// Depth pixel to 3-D point back-projection over a strided scan rectangle.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock unless back pressure has stalled stage 1.
// A kept pixel moves through the stage 1 to stage 4 registers in order and shows
// up as a valid point word on the output from stage 4. The block is a four-stage
// pipeline: stage 1 registers the offset from the principal point and the
// rectangle/depth verdict, stage 2 multiplies the offset by depth (and forms
// the stride quotient), stage 3 multiplies by the reciprocal focal length (and
// checks the stride remainder), and stage 4 is the output register holding the
// floored, saturated coordinates. Each stage has its own valid bit and loads
// whenever it is empty or its successor moves, so bubbles close up and back
// pressure on the output only stalls the stages behind a full one. Dropped
// pixels leave no word. Nothing is accepted while reset is held.
// Configuration is write-only and is expected to change only while the
// pipeline is empty. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module depth_rect_backprojection_top #(
    parameter int unsigned SAMPLE_STRIDE  = 3,     // 1 .. 16
    parameter int unsigned NEAR_DEPTH_RAW = 100    // exclusive near limit
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    drbp_pixel_if.sink                        i_pix,
    drbp_point_if.source                      o_pt,
    input  logic                              i_cfg_we,
    input  logic [drbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drbp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import drbp_pkg::*;

    t_cfg      cfg;
    t_stage_en en;

    // valid bits per stage
    logic r_v1, r_v2, r_v3, r_v4;
    logic pre_ok, stride_ok, accept;

    // depth and color riding along
    t_pass n_pass;
    t_pass r_pass1, r_pass2, r_pass3, r_pass4;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    drbp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // flow control: a stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    assign en.s4 = !r_v4 || o_pt.ready;
    assign en.s3 = !r_v3 || en.s4;
    assign en.s2 = !r_v2 || en.s3;
    assign en.s1 = !r_v1 || en.s2;

    // no handshake completes while reset is held
    assign i_pix.ready = en.s1 && i_rst_n;
    assign accept      = i_pix.valid && en.s1 && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= accept && pre_ok;      // drop out-of-window pixels
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2 && stride_ok;     // drop off-grid pixels
            if (en.s4) r_v4 <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // pass-through fields
    // ------------------------------------------------------------------
    assign n_pass.depth = i_pix.depth_raw;
    assign n_pass.red   = i_pix.red_in;
    assign n_pass.green = i_pix.green_in;
    assign n_pass.blue  = i_pix.blue_in;

    always_ff @(posedge i_clk) begin
        if (en.s1) r_pass1 <= n_pass;
        if (en.s2) r_pass2 <= r_pass1;
        if (en.s3) r_pass3 <= r_pass2;
        if (en.s4) r_pass4 <= r_pass3;
    end

    // ------------------------------------------------------------------
    // window, depth and stride tests
    // ------------------------------------------------------------------
    drbp_sample_gate #(
        .SAMPLE_STRIDE  (SAMPLE_STRIDE),
        .NEAR_DEPTH_RAW (NEAR_DEPTH_RAW)
    ) u_gate (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_cfg       (cfg),
        .i_col       (i_pix.pixel_col),
        .i_row       (i_pix.pixel_row),
        .i_depth     (i_pix.depth_raw),
        .o_pre_ok    (pre_ok),
        .o_stride_ok (stride_ok)
    );

    // ------------------------------------------------------------------
    // projection, one unit per axis
    // ------------------------------------------------------------------
    drbp_axis_proj u_proj_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pos    (i_pix.pixel_col),
        .i_center (cfg.cx),
        .i_depth  (r_pass1.depth),
        .i_inv    (cfg.inv_focal_x),
        .o_coord  (o_pt.point_x)
    );

    drbp_axis_proj u_proj_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pos    (i_pix.pixel_row),
        .i_center (cfg.cy),
        .i_depth  (r_pass1.depth),
        .i_inv    (cfg.inv_focal_y),
        .o_coord  (o_pt.point_y)
    );

    // ------------------------------------------------------------------
    // output word
    // ------------------------------------------------------------------
    assign o_pt.valid     = r_v4;
    assign o_pt.point_z   = r_pass4.depth;
    assign o_pt.red_out   = r_pass4.red;
    assign o_pt.green_out = r_pass4.green;
    assign o_pt.blue_out  = r_pass4.blue;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a word in stage 3 reaches the output when the output stage loads
    a_s3_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && en.s4) |=> o_pt.valid)
        else $error("stage 3 word lost on its way to the output");

    // a pixel at or under the near limit never enters the pipeline
    a_near_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_pix.depth_raw <= DEPTH_W'(NEAR_DEPTH_RAW))) |=> !r_v1)
        else $error("near pixel entered the pipeline");

    // every emitted point lies beyond the near limit
    a_out_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid |-> (o_pt.point_z > DEPTH_W'(NEAR_DEPTH_RAW)))
        else $error("output word with depth at or under the near limit");

endmodule

FILE: hw/rtl/drbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// drbp_cfg_regs
// Write-only configuration register file.
// ----------------------------------------------------------------------------
module drbp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [drbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [drbp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output drbp_pkg::t_cfg                      o_cfg
);
    import drbp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RECT_LEFT:       n_cfg.rect_left     = i_cfg_wdata[COORD_W-1:0];
                CFG_RECT_TOP:        n_cfg.rect_top      = i_cfg_wdata[COORD_W-1:0];
                CFG_RECT_RIGHT:      n_cfg.rect_right    = i_cfg_wdata[BOUND_W-1:0];
                CFG_RECT_BOTTOM:     n_cfg.rect_bottom   = i_cfg_wdata[BOUND_W-1:0];
                CFG_PRINCIPAL_POINT: begin
                    n_cfg.cx = i_cfg_wdata[CENTER_W-1:0];
                    n_cfg.cy = i_cfg_wdata[2*CENTER_W-1:CENTER_W];
                end
                CFG_INV_FOCAL_X:     n_cfg.inv_focal_x   = i_cfg_wdata[INV_W-1:0];
                CFG_INV_FOCAL_Y:     n_cfg.inv_focal_y   = i_cfg_wdata[INV_W-1:0];
                CFG_MAX_DEPTH_RAW:   n_cfg.max_depth_raw = i_cfg_wdata[DEPTH_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg               <= '0;
            r_cfg.max_depth_raw <= '1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/drbp_sample_gate.sv
// ----------------------------------------------------------------------------
// drbp_sample_gate
// Rectangle / depth window test and pipelined stride-grid remainder check.
// ----------------------------------------------------------------------------
module drbp_sample_gate #(
    parameter int unsigned SAMPLE_STRIDE  = 3,
    parameter int unsigned NEAR_DEPTH_RAW = 100
) (
    input  logic                             i_clk,
    input  drbp_pkg::t_stage_en              i_en,
    input  drbp_pkg::t_cfg                   i_cfg,
    input  logic [drbp_pkg::COORD_W-1:0]     i_col,
    input  logic [drbp_pkg::COORD_W-1:0]     i_row,
    input  logic [drbp_pkg::DEPTH_W-1:0]     i_depth,
    output logic                             o_pre_ok,     // comb, feeds stage 1
    output logic                             o_stride_ok   // comb from stage 2
);
    import drbp_pkg::*;

    // ceil(2^24 / stride)
    localparam logic [RECIP_W-1:0] RecipMul =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLE_STRIDE) - 64'd1) / 64'(SAMPLE_STRIDE));
    localparam logic [DEPTH_W-1:0] NearLimit = DEPTH_W'(NEAR_DEPTH_RAW);
    localparam int unsigned PROD_W = COORD_W + RECIP_W;
    localparam int unsigned BACK_W = COORD_W + 5;

    logic in_cols, in_rows, depth_ok;

    logic [COORD_W-1:0] r_off_c1, r_off_r1;
    logic [COORD_W-1:0] r_off_c2, r_off_r2;
    logic [COORD_W-1:0] r_q_c2, r_q_r2;

    logic [PROD_W-1:0]  prod_c, prod_r;
    logic [BACK_W-1:0]  back_c, back_r;

    assign in_cols  = (i_col >= i_cfg.rect_left) && ({1'b0, i_col} < i_cfg.rect_right);
    assign in_rows  = (i_row >= i_cfg.rect_top)  && ({1'b0, i_row} < i_cfg.rect_bottom);
    assign depth_ok = (i_depth > NearLimit) && (i_depth <= i_cfg.max_depth_raw);
    assign o_pre_ok = in_cols && in_rows && depth_ok;

    // stage 1: offsets from the rectangle corner
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_off_c1 <= i_col - i_cfg.rect_left;
            r_off_r1 <= i_row - i_cfg.rect_top;
        end
    end

    // stage 2: quotient by reciprocal multiply
    assign prod_c = PROD_W'(r_off_c1) * PROD_W'(RecipMul);
    assign prod_r = PROD_W'(r_off_r1) * PROD_W'(RecipMul);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_off_c2 <= r_off_c1;
            r_off_r2 <= r_off_r1;
            r_q_c2   <= prod_c[RECIP_SHIFT +: COORD_W];
            r_q_r2   <= prod_r[RECIP_SHIFT +: COORD_W];
        end
    end

    // remainder is zero when q * stride gives the offset back
    assign back_c = BACK_W'(r_q_c2) * BACK_W'(SAMPLE_STRIDE);
    assign back_r = BACK_W'(r_q_r2) * BACK_W'(SAMPLE_STRIDE);
    assign o_stride_ok = (back_c == BACK_W'(r_off_c2)) && (back_r == BACK_W'(r_off_r2));

endmodule

FILE: hw/rtl/drbp_axis_proj.sv
// ----------------------------------------------------------------------------
// drbp_axis_proj
// One axis of the back-projection: ((pos*16 - c) * d * inv) >>> 24, saturated.
// ----------------------------------------------------------------------------
module drbp_axis_proj (
    input  logic                                    i_clk,
    input  drbp_pkg::t_stage_en                     i_en,
    input  logic [drbp_pkg::COORD_W-1:0]            i_pos,
    input  logic [drbp_pkg::CENTER_W-1:0]           i_center,
    input  logic [drbp_pkg::DEPTH_W-1:0]            i_depth,   // from stage 1
    input  logic [drbp_pkg::INV_W-1:0]              i_inv,
    output logic signed [drbp_pkg::POINT_W-1:0]     o_coord
);
    import drbp_pkg::*;

    localparam int unsigned DIFF_W = CENTER_W + 1;
    localparam int unsigned P1_W   = DIFF_W + DEPTH_W;       // 33
    localparam int unsigned P2_W   = P1_W + INV_W;           // 57
    localparam int unsigned SH_W   = P2_W - FRAC_SHIFT;      // 33
    localparam logic signed [POINT_W-1:0] SatMax = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic signed [POINT_W-1:0] SatMin = {1'b1, {(POINT_W-1){1'b0}}};

    logic signed [DIFF_W-1:0]   n_diff, r_diff;
    logic signed [P1_W:0]       p1_full;
    logic signed [P1_W-1:0]     r_p1;
    logic signed [P2_W:0]       p2_full;
    logic signed [P2_W-1:0]     r_p2;
    logic signed [SH_W-1:0]     sh;
    logic signed [POINT_W-1:0]  n_coord, r_coord;

    // stage 1: signed offset from the principal point (4 fraction bits)
    assign n_diff = $signed({1'b0, i_pos, 4'b0000}) - $signed({1'b0, i_center});

    always_ff @(posedge i_clk) begin
        if (i_en.s1) r_diff <= n_diff;
    end

    // stage 2: times depth
    assign p1_full = r_diff * $signed({1'b0, i_depth});

    always_ff @(posedge i_clk) begin
        if (i_en.s2) r_p1 <= p1_full[P1_W-1:0];
    end

    // stage 3: times 1/f
    assign p2_full = r_p1 * $signed({1'b0, i_inv});

    always_ff @(posedge i_clk) begin
        if (i_en.s3) r_p2 <= p2_full[P2_W-1:0];
    end

    // stage 4: floor shift and clamp
    assign sh = r_p2[P2_W-1:FRAC_SHIFT];

    always_comb begin
        if (sh[SH_W-1] == sh[POINT_W-1]) begin
            n_coord = sh[POINT_W-1:0];
        end else if (sh[SH_W-1]) begin
            n_coord = SatMin;
        end else begin
            n_coord = SatMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) r_coord <= n_coord;
    end

    assign o_coord = r_coord;

endmodule
